>>> hw/rtl/jkmof_pkg.sv
package jkmof_pkg;

  // Field widths
  localparam int PT_W    = 16;
  localparam int ETA_W   = 14;
  localparam int PHI_W   = 13;
  localparam int MASS_W  = 16;
  localparam int BTAG_W  = 12;
  localparam int LIM_W   = 13;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Angle fixed point: LSB is 2^-ANGLE_FRAC_BITS
  localparam int ANGLE_FRAC_BITS = 10;

  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint PI_FX_L =
    (PI_Q30 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
  localparam longint TWO_PI_FX_L =
    (TWO_PI_Q30 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);

  // Phi wrap arithmetic
  localparam int WRAP_W = 18;
  localparam int WRAP_STEPS = int'(((64'sd1 <<< PHI_W) + PI_FX_L) / TWO_PI_FX_L) + 1;
  localparam logic signed [WRAP_W-1:0] PI_FX     = WRAP_W'(PI_FX_L);
  localparam logic signed [WRAP_W-1:0] NEG_PI_FX = WRAP_W'(-PI_FX_L);
  localparam logic signed [WRAP_W-1:0] TWO_PI_FX = WRAP_W'(TWO_PI_FX_L);

  // Delta widths
  localparam int DE_W  = ETA_W + 1;
  localparam int DP_W  = $clog2(int'(PI_FX_L) + 1) + 1;
  localparam int DE_SQ_W = 2 * DE_W;
  localparam int DP_SQ_W = 2 * DP_W;
  localparam int DR_SQ_W = 2 * LIM_W;
  localparam int SUM_W   = DE_SQ_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PT_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DR_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BTAG_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BJET_ETA_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_BJETS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MUON_VETO    = 3'd6;

  // Register reset values
  localparam logic [PT_W-1:0]          PT_MIN_RST       = 16'd480;
  localparam logic [LIM_W-1:0]         ETA_MAX_RST      = 13'd4813;
  localparam logic [LIM_W-1:0]         DR_MIN_RST       = 13'd307;
  localparam logic signed [BTAG_W-1:0] BTAG_MIN_RST     = 12'sd819;
  localparam logic [LIM_W-1:0]         BJET_ETA_MAX_RST = 13'd2458;

  // Per-stage load strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } load_t;

  // Jet payload carried along the pipeline
  typedef struct packed {
    logic [PT_W-1:0]          pt;
    logic signed [ETA_W-1:0]  eta;
    logic signed [PHI_W-1:0]  phi;
    logic [MASS_W-1:0]        mass;
    logic                     last;
    logic                     kin;
  } jet_t;

endpackage

>>> hw/rtl/jkmof_dr_unit.sv
// Squared delta-R between jet and one muon, three register stages.
module jkmof_dr_unit (
  input  logic                                   clk,
  input  jkmof_pkg::load_t                       ld,
  input  logic signed [jkmof_pkg::ETA_W-1:0]     jet_eta,
  input  logic signed [jkmof_pkg::PHI_W-1:0]     jet_phi,
  input  logic signed [jkmof_pkg::ETA_W-1:0]     mu_eta,
  input  logic signed [jkmof_pkg::PHI_W-1:0]     mu_phi,
  input  logic [jkmof_pkg::DR_SQ_W-1:0]          dr_sq,
  output logic                                   close
);

  logic signed [jkmof_pkg::DE_W-1:0]     de1_r, de2_r;
  logic signed [jkmof_pkg::DE_W-1:0]     de_nxt;
  logic signed [jkmof_pkg::PHI_W:0]      dphi1_r, dphi_nxt;
  logic signed [jkmof_pkg::DP_W-1:0]     dp2_r, dp_nxt;
  logic signed [jkmof_pkg::WRAP_W-1:0]   wrap;
  logic signed [jkmof_pkg::DE_SQ_W-1:0]  de_prod;
  logic signed [jkmof_pkg::DP_SQ_W-1:0]  dp_prod;
  logic [jkmof_pkg::DE_SQ_W-1:0]         de_sq3_r;
  logic [jkmof_pkg::DP_SQ_W-1:0]         dp_sq3_r;
  logic [jkmof_pkg::SUM_W-1:0]           sum;

  // Stage 1: raw differences
  assign de_nxt   = jkmof_pkg::DE_W'(jet_eta) - jkmof_pkg::DE_W'(mu_eta);
  assign dphi_nxt = (jkmof_pkg::PHI_W + 1)'(jet_phi) - (jkmof_pkg::PHI_W + 1)'(mu_phi);

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      de1_r   <= de_nxt;
      dphi1_r <= dphi_nxt;
    end
  end

  // Stage 2: bring dphi into [-pi, pi)
  always_comb begin
    wrap = jkmof_pkg::WRAP_W'(dphi1_r);
    for (int i = 0; i < jkmof_pkg::WRAP_STEPS; i++) begin
      if (wrap >= jkmof_pkg::PI_FX) begin
        wrap = wrap - jkmof_pkg::TWO_PI_FX;
      end
    end
    for (int i = 0; i < jkmof_pkg::WRAP_STEPS; i++) begin
      if (wrap < jkmof_pkg::NEG_PI_FX) begin
        wrap = wrap + jkmof_pkg::TWO_PI_FX;
      end
    end
    dp_nxt = wrap[jkmof_pkg::DP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      de2_r <= de1_r;
      dp2_r <= dp_nxt;
    end
  end

  // Stage 3: squares
  assign de_prod = jkmof_pkg::DE_SQ_W'(de2_r) * jkmof_pkg::DE_SQ_W'(de2_r);
  assign dp_prod = jkmof_pkg::DP_SQ_W'(dp2_r) * jkmof_pkg::DP_SQ_W'(dp2_r);

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      de_sq3_r <= $unsigned(de_prod);
      dp_sq3_r <= $unsigned(dp_prod);
    end
  end

  // Sum and compare, registered by the caller
  assign sum   = jkmof_pkg::SUM_W'(de_sq3_r) + jkmof_pkg::SUM_W'(dp_sq3_r);
  assign close = sum < jkmof_pkg::SUM_W'(dr_sq);

endmodule

>>> hw/rtl/jet_kinematic_muon_overlap_filter.sv
// Jet selection with muon overlap removal. Each accepted input transaction
// carries one jet plus the two muon positions of its event and produces
// exactly one output transaction, in order. A jet is accepted when
// pt > pt_min and |eta| is below eta_max (or, with select_bjets set, when
// pt > pt_min, btag > btag_min and |eta| is below bjet_eta_max instead),
// and, with apply_muon_veto set, its delta-R to both muons is at least
// dr_min. near_muon is reported whether or not the veto is enabled.
// Delta-R is compared squared; delta-phi is wrapped into [-pi, pi).
// Angles are in units of 1/1024, pt and mass in 1/16 GeV. Throughput is
// one jet per clock while out_ready holds; the stages are difference, phi
// wrap, squaring multipliers, compare into the output register. Each stage
// holds when the one after it is full and stalled, so bubbles are
// squeezed out and input stays open while a result waits at the output.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data with the
// pipeline empty; unknown indexes are ignored.
module jet_kinematic_muon_overlap_filter (
  input  logic                                    clk,
  input  logic                                    rst_n,

  input  logic                                    cfg_wr_en,
  input  logic [jkmof_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [jkmof_pkg::CFG_W-1:0]             cfg_data,

  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [jkmof_pkg::PT_W-1:0]              in_jet_pt,
  input  logic signed [jkmof_pkg::ETA_W-1:0]      in_jet_eta,
  input  logic signed [jkmof_pkg::PHI_W-1:0]      in_jet_phi,
  input  logic [jkmof_pkg::MASS_W-1:0]            in_jet_mass,
  input  logic signed [jkmof_pkg::BTAG_W-1:0]     in_jet_btag,
  input  logic signed [jkmof_pkg::ETA_W-1:0]      in_muon_a_eta,
  input  logic signed [jkmof_pkg::PHI_W-1:0]      in_muon_a_phi,
  input  logic signed [jkmof_pkg::ETA_W-1:0]      in_muon_b_eta,
  input  logic signed [jkmof_pkg::PHI_W-1:0]      in_muon_b_phi,
  input  logic                                    in_last_jet,

  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_accepted,
  output logic                                    out_near_muon,
  output logic [jkmof_pkg::PT_W-1:0]              out_pt,
  output logic signed [jkmof_pkg::ETA_W-1:0]      out_eta,
  output logic signed [jkmof_pkg::PHI_W-1:0]      out_phi,
  output logic [jkmof_pkg::MASS_W-1:0]            out_mass,
  output logic                                    out_end_of_event
);

  // Config registers
  logic [jkmof_pkg::PT_W-1:0]          pt_min_r;
  logic [jkmof_pkg::LIM_W-1:0]         eta_max_r;
  logic [jkmof_pkg::LIM_W-1:0]         dr_min_r;
  logic signed [jkmof_pkg::BTAG_W-1:0] btag_min_r;
  logic [jkmof_pkg::LIM_W-1:0]         bjet_eta_max_r;
  logic                                select_bjets_r;
  logic                                muon_veto_r;
  logic [jkmof_pkg::DR_SQ_W-1:0]       dr_sq_r;

  // Pipeline control
  jkmof_pkg::load_t ld;
  logic             ld_out;
  logic             v1_r, v2_r, v3_r, out_valid_r;

  // Payload
  jkmof_pkg::jet_t  jet_nxt, jet1_r, jet2_r, jet3_r;
  logic [jkmof_pkg::ETA_W-1:0] abs_eta;
  logic             kin_nxt;
  logic             close_a, close_b;
  logic             near_nxt;

  logic                               accepted_r, near_r, last_r;
  logic [jkmof_pkg::PT_W-1:0]         pt_r;
  logic signed [jkmof_pkg::ETA_W-1:0] eta_r;
  logic signed [jkmof_pkg::PHI_W-1:0] phi_r;
  logic [jkmof_pkg::MASS_W-1:0]       mass_r;

  // ---------------------------------------------------------------------
  // Configuration writes; excess data bits are dropped
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_min_r       <= jkmof_pkg::PT_MIN_RST;
      eta_max_r      <= jkmof_pkg::ETA_MAX_RST;
      dr_min_r       <= jkmof_pkg::DR_MIN_RST;
      btag_min_r     <= jkmof_pkg::BTAG_MIN_RST;
      bjet_eta_max_r <= jkmof_pkg::BJET_ETA_MAX_RST;
      select_bjets_r <= 1'b0;
      muon_veto_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        jkmof_pkg::REG_PT_MIN:       pt_min_r       <= cfg_data[jkmof_pkg::PT_W-1:0];
        jkmof_pkg::REG_ETA_MAX:      eta_max_r      <= cfg_data[jkmof_pkg::LIM_W-1:0];
        jkmof_pkg::REG_DR_MIN:       dr_min_r       <= cfg_data[jkmof_pkg::LIM_W-1:0];
        jkmof_pkg::REG_BTAG_MIN:     btag_min_r     <= cfg_data[jkmof_pkg::BTAG_W-1:0];
        jkmof_pkg::REG_BJET_ETA_MAX: bjet_eta_max_r <= cfg_data[jkmof_pkg::LIM_W-1:0];
        jkmof_pkg::REG_SELECT_BJETS: select_bjets_r <= cfg_data[0];
        jkmof_pkg::REG_MUON_VETO:    muon_veto_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Squared radius, refreshed every cycle (the user must change config only when idle; the block does not enforce this)
  always_ff @(posedge clk) begin
    dr_sq_r <= jkmof_pkg::DR_SQ_W'(dr_min_r) * jkmof_pkg::DR_SQ_W'(dr_min_r);
  end

  // ---------------------------------------------------------------------
  // Stage loads: a stage takes new data when empty or when its
  // successor is taking its current contents.
  // ---------------------------------------------------------------------
  assign ld_out   = !out_valid_r || out_ready;
  assign ld.s3    = !v3_r || ld_out;
  assign ld.s2    = !v2_r || ld.s3;
  assign ld.s1    = !v1_r || ld.s2;
  assign in_ready = ld.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld.s1)  v1_r        <= in_valid;
      if (ld.s2)  v2_r        <= v1_r;
      if (ld.s3)  v3_r        <= v2_r;
      if (ld_out) out_valid_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: kinematic cuts, evaluated up front and carried along
  // ---------------------------------------------------------------------
  assign abs_eta = in_jet_eta[jkmof_pkg::ETA_W-1] ? jkmof_pkg::ETA_W'(-in_jet_eta)
                                                   : jkmof_pkg::ETA_W'(in_jet_eta);

  always_comb begin
    if (select_bjets_r) begin
      kin_nxt = (in_jet_pt > pt_min_r) && (in_jet_btag > btag_min_r) &&
                (abs_eta < jkmof_pkg::ETA_W'(bjet_eta_max_r));
    end else begin
      kin_nxt = (in_jet_pt > pt_min_r) && (abs_eta < jkmof_pkg::ETA_W'(eta_max_r));
    end
    jet_nxt.pt   = in_jet_pt;
    jet_nxt.eta  = in_jet_eta;
    jet_nxt.phi  = in_jet_phi;
    jet_nxt.mass = in_jet_mass;
    jet_nxt.last = in_last_jet;
    jet_nxt.kin  = kin_nxt;
  end

  always_ff @(posedge clk) begin
    if (ld.s1) jet1_r <= jet_nxt;
    if (ld.s2) jet2_r <= jet1_r;
    if (ld.s3) jet3_r <= jet2_r;
  end

  // ---------------------------------------------------------------------
  // Delta-R units, one per muon
  // ---------------------------------------------------------------------
  jkmof_dr_unit u_dr_a (
    .clk     (clk),
    .ld      (ld),
    .jet_eta (in_jet_eta),
    .jet_phi (in_jet_phi),
    .mu_eta  (in_muon_a_eta),
    .mu_phi  (in_muon_a_phi),
    .dr_sq   (dr_sq_r),
    .close   (close_a)
  );

  jkmof_dr_unit u_dr_b (
    .clk     (clk),
    .ld      (ld),
    .jet_eta (in_jet_eta),
    .jet_phi (in_jet_phi),
    .mu_eta  (in_muon_b_eta),
    .mu_phi  (in_muon_b_phi),
    .dr_sq   (dr_sq_r),
    .close   (close_b)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  assign near_nxt = close_a || close_b;

  always_ff @(posedge clk) begin
    if (ld_out) begin
      accepted_r <= jet3_r.kin && !(muon_veto_r && near_nxt);
      near_r     <= near_nxt;
      pt_r       <= jet3_r.pt;
      eta_r      <= jet3_r.eta;
      phi_r      <= jet3_r.phi;
      mass_r     <= jet3_r.mass;
      last_r     <= jet3_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = accepted_r;
  assign out_near_muon    = near_r;
  assign out_pt           = pt_r;
  assign out_eta          = eta_r;
  assign out_phi          = phi_r;
  assign out_mass         = mass_r;
  assign out_end_of_event = last_r;

endmodule
